>>> src/rcmsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mode switch toggle decoder.
// No dependencies; used by rcmsw_toggle_fsm and the top level.
package rcmsw_pkg;

  // Bits of the pulse width that the decoder looks at.
  localparam int unsigned PulseBits = 16;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgThresholdLow  = 3'd0,
    CfgThresholdHigh = 3'd1,
    CfgToggleTimeout = 3'd2,
    CfgTwoPosition   = 3'd3,
    CfgDatalinkMode  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeManual = 2'd0,
    ModeStab   = 2'd1,
    ModeAuto   = 2'd2
  } mode_e;

  // Toggle machine phases, one-hot.
  typedef enum logic [11:0] {
    PhEntManLt  = 12'b0000_0000_0001,
    PhManLt     = 12'b0000_0000_0010,
    PhEntStabLt = 12'b0000_0000_0100,
    PhStabLt    = 12'b0000_0000_1000,
    PhEntManT1  = 12'b0000_0001_0000,
    PhManT1     = 12'b0000_0010_0000,
    PhEntStabT1 = 12'b0000_0100_0000,
    PhStabT1    = 12'b0000_1000_0000,
    PhManT2     = 12'b0001_0000_0000,
    PhEntManT2  = 12'b0010_0000_0000,
    PhEntAuto   = 12'b0100_0000_0000,
    PhAuto      = 12'b1000_0000_0000
  } phase_e;

  // Settings the toggle machine needs from the register file.
  typedef struct packed {
    logic [PulseBits-1:0] threshold_low;
    logic [15:0]          toggle_timeout;
    logic                 datalink_mode;
  } tog_cfg_t;

endpackage

>>> src/rc_mode_switch_toggle_decoder.sv
`timescale 1ns / 1ps
// RC flight-mode switch decoder: toggle-sequence or three-position decoding,
// failsafe hold and radio-loss handling. Depends on rcmsw_pkg, rcmsw_toggle_fsm.
// Pipeline: an accepted input beat is captured in the input register, then moves
// on to the result register. Throughput: one tick per cycle while out_stall_i is low.
// Reset: asynchronous, active low; restores register defaults, manual mode,
// clears the hold and latched requests and empties both pipeline stages.
module rc_mode_switch_toggle_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [15:0]                     pulse_width_i,
  input  logic                            link_up_i,
  input  logic                            hold_set_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            manual_request_o,
  output logic                            stabilize_request_o,
  output logic                            home_request_o,
  output logic                            hold_active_o,
  output logic [1:0]                      decoded_mode_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcmsw_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [rcmsw_pkg::CfgDataBits-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [15:0] thr_low_q, thr_high_q, timeout_q;
  logic        two_pos_q, datalink_q;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q  <= 16'd3000;
      thr_high_q <= 16'd3500;
      timeout_q  <= 16'd20;
      two_pos_q  <= 1'b1;
      datalink_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        rcmsw_pkg::CfgThresholdLow:  thr_low_q  <= cfg_data_i;
        rcmsw_pkg::CfgThresholdHigh: thr_high_q <= cfg_data_i;
        rcmsw_pkg::CfgToggleTimeout: timeout_q  <= cfg_data_i;
        rcmsw_pkg::CfgTwoPosition:   two_pos_q  <= cfg_data_i[0];
        rcmsw_pkg::CfgDatalinkMode:  datalink_q <= cfg_data_i[0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register stage. Hold the beat while the result side is full.
  // ---------------------------------------------------------------------------
  logic                          s1_valid_q, s1_valid_d;
  logic [rcmsw_pkg::PulseBits-1:0] pw_q;
  logic                          radio_q, hold_set_q;
  logic                          in_take, adv;
  logic                          out_valid_q, out_valid_d;

  // Advance the tick into the result register when that slot frees up.
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_take || (s1_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pw_q       <= pulse_width_i[rcmsw_pkg::PulseBits-1:0];
      radio_q    <= link_up_i;
      hold_set_q <= hold_set_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Toggle machine: stepped once per advancing tick, only in two-position mode.
  // ---------------------------------------------------------------------------
  rcmsw_pkg::tog_cfg_t tog_cfg;
  rcmsw_pkg::mode_e    mode_next;

  assign tog_cfg.threshold_low  = thr_low_q[rcmsw_pkg::PulseBits-1:0];
  assign tog_cfg.toggle_timeout = timeout_q;
  assign tog_cfg.datalink_mode  = datalink_q;

  rcmsw_toggle_fsm u_toggle_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .run_i       (two_pos_q),
    .pulse_i     (pw_q),
    .cfg_i       (tog_cfg),
    .mode_next_o (mode_next)
  );

  // ---------------------------------------------------------------------------
  // Request flags: machine first, then threshold decode, hold and radio loss.
  // req bits: [0] manual, [1] stabilize, [2] home.
  // ---------------------------------------------------------------------------
  logic [2:0] req_dec, req_out;
  logic [2:0] latched_q, latched_d;
  logic       hold_q, hold_d, hold_in;

  always_comb begin
    if (two_pos_q) begin
      case (mode_next)
        rcmsw_pkg::ModeAuto: req_dec = 3'b100;
        rcmsw_pkg::ModeStab: req_dec = 3'b010;
        default:             req_dec = 3'b001; // code 3 reads as manual
      endcase
    end else if (pw_q > thr_high_q[rcmsw_pkg::PulseBits-1:0]) begin
      req_dec = 3'b100;
    end else if (pw_q > thr_low_q[rcmsw_pkg::PulseBits-1:0]) begin
      req_dec = 3'b010;
    end else begin
      req_dec = datalink_q ? 3'b010 : 3'b001;
    end
  end

  assign hold_in = hold_q || hold_set_q;

  always_comb begin
    req_out   = req_dec;
    latched_d = latched_q;
    hold_d    = hold_in;
    if (!radio_q) begin
      // Radio lost: request home, leave the latch alone; a new hold request still sets the hold.
      req_out = 3'b100;
    end else if (hold_in) begin
      if (req_dec == latched_q) begin
        req_out = 3'b000;
      end else begin
        // Switch pattern changed: release the hold.
        latched_d = req_dec;
        hold_d    = 1'b0;
      end
    end else begin
      latched_d = req_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= 1'b0;
      latched_q <= '0;
    end else if (adv) begin
      hold_q    <= hold_d;
      latched_q <= latched_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [2:0] req_q;
  logic       hold_out_q;
  logic [1:0] mode_out_q;

  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req_q      <= req_out;
      hold_out_q <= hold_d;
      mode_out_q <= mode_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign manual_request_o    = req_q[0];
  assign stabilize_request_o = req_q[1];
  assign home_request_o      = req_q[2];
  assign hold_active_o       = hold_out_q;
  assign decoded_mode_o      = mode_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_req_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({manual_request_o, stabilize_request_o, home_request_o}))
    else $error("more than one mode request asserted");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (decoded_mode_o != 2'd3))
    else $error("decoded mode holds an unused code");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_hold_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && radio_q && hold_in && req_dec != latched_q) |=> !hold_q)
    else $error("hold not released on switch pattern change");

endmodule

>>> src/rcmsw_toggle_fsm.sv
`timescale 1ns / 1ps
// Two-position toggle sequence machine with its inter-toggle tick counter.
// Depends on rcmsw_pkg.
module rcmsw_toggle_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          run_i,
  input  logic [rcmsw_pkg::PulseBits-1:0] pulse_i,
  input  rcmsw_pkg::tog_cfg_t           cfg_i,
  output rcmsw_pkg::mode_e              mode_next_o
);

  rcmsw_pkg::phase_e phase_q, phase_d;
  rcmsw_pkg::mode_e  mode_q, mode_d;
  logic [15:0]       ticks_q, ticks_d;
  logic [15:0]       ticks_inc;
  logic              up, down, late;

  assign up        = pulse_i > cfg_i.threshold_low;
  assign down      = pulse_i < cfg_i.threshold_low;
  assign late      = ticks_q > cfg_i.toggle_timeout;
  // Saturate at full scale.
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    mode_d  = mode_q;
    ticks_d = ticks_q;
    unique case (phase_q) inside
      rcmsw_pkg::PhEntManLt: begin
        ticks_d = '0;
        mode_d  = rcmsw_pkg::ModeManual;
        phase_d = rcmsw_pkg::PhManLt;
      end
      rcmsw_pkg::PhManLt: begin
        if (up) phase_d = rcmsw_pkg::PhEntStabLt;
      end
      rcmsw_pkg::PhEntStabLt: begin
        ticks_d = '0;
        mode_d  = rcmsw_pkg::ModeStab;
        phase_d = rcmsw_pkg::PhStabLt;
      end
      rcmsw_pkg::PhStabLt: begin
        if (down && !cfg_i.datalink_mode) phase_d = rcmsw_pkg::PhEntManT1;
      end
      rcmsw_pkg::PhEntManT1, rcmsw_pkg::PhEntManT2: begin
        ticks_d = '0;
        if (cfg_i.datalink_mode) begin
          // Datalink: stay stabilized instead of entering a manual toggle.
          mode_d  = rcmsw_pkg::ModeStab;
          phase_d = rcmsw_pkg::PhStabT1;
        end else begin
          mode_d  = rcmsw_pkg::ModeManual;
          phase_d = (phase_q == rcmsw_pkg::PhEntManT1) ? rcmsw_pkg::PhManT1
                                                       : rcmsw_pkg::PhManT2;
        end
      end
      rcmsw_pkg::PhManT1: begin
        if (up) phase_d = rcmsw_pkg::PhEntStabT1;
        else if (late) phase_d = rcmsw_pkg::PhEntManLt;
        ticks_d = ticks_inc;
      end
      rcmsw_pkg::PhEntStabT1: begin
        ticks_d = '0;
        mode_d  = rcmsw_pkg::ModeStab;
        phase_d = rcmsw_pkg::PhStabT1;
      end
      rcmsw_pkg::PhStabT1: begin
        if (down) begin
          if (!cfg_i.datalink_mode) phase_d = rcmsw_pkg::PhEntManT2;
        end else if (late) begin
          phase_d = rcmsw_pkg::PhEntStabLt;
        end
        ticks_d = ticks_inc;
      end
      rcmsw_pkg::PhManT2: begin
        if (up) phase_d = rcmsw_pkg::PhEntAuto;
        else if (late) phase_d = rcmsw_pkg::PhEntManLt;
        ticks_d = ticks_inc;
      end
      rcmsw_pkg::PhEntAuto: begin
        ticks_d = '0;
        mode_d  = rcmsw_pkg::ModeAuto;
        phase_d = rcmsw_pkg::PhAuto;
      end
      rcmsw_pkg::PhAuto: begin
        if (down) phase_d = rcmsw_pkg::PhEntManLt;
      end
      default: phase_d = rcmsw_pkg::PhEntManLt;
    endcase
  end

  // Frozen mode reports the held request.
  assign mode_next_o = run_i ? mode_d : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rcmsw_pkg::PhManLt;
      mode_q  <= rcmsw_pkg::ModeManual;
      ticks_q <= '0;
    end else if (step_i && run_i) begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      ticks_q <= ticks_d;
    end
  end

endmodule
